[design/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue and its storage cells.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned MODE_WIDTH = 2;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned OP_COUNT_WIDTH = 32;

   localparam logic signed [WORD_WIDTH-1:0] EMPTY_WORD = -32'sd1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PUSH_LEFT  = 2'd0,
      MODE_PUSH_RIGHT = 2'd1,
      MODE_POP_LEFT   = 2'd2,
      MODE_POP_RIGHT  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_POP_EMPTY  = 2'd1,
      STATUS_PUSH_FULL  = 2'd2
   } status_type;

   // operation broadcast to every cell, already qualified by full and empty
   typedef struct packed {
      logic                  push_left;
      logic                  push_right;
      logic                  pop_left;
      logic                  pop_right;
      logic [WORD_WIDTH-1:0] word;
   } cmd_type;

endpackage

[design/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell. Holds one slot of the left-packed row and one slot of the
// right-packed row, and shifts each towards a neighbour or loads the pushed word as the operation asks.
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned INDEX = 0,
   localparam int unsigned CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  dq_pkg::cmd_type                     cmd,
   input  logic [CountWidth-1:0]               held,
   input  logic [dq_pkg::WORD_WIDTH-1:0]       a_left_in,
   input  logic [dq_pkg::WORD_WIDTH-1:0]       a_right_in,
   input  logic [dq_pkg::WORD_WIDTH-1:0]       b_left_in,
   input  logic [dq_pkg::WORD_WIDTH-1:0]       b_right_in,
   output logic [dq_pkg::WORD_WIDTH-1:0]       a_out,
   output logic [dq_pkg::WORD_WIDTH-1:0]       b_out
);

   localparam logic [CountWidth-1:0] APos = CountWidth'(INDEX);
   localparam logic [CountWidth-1:0] BPos = CountWidth'(DEPTH - 1 - INDEX);

   logic [dq_pkg::WORD_WIDTH-1:0] a_ff, a_in;
   logic [dq_pkg::WORD_WIDTH-1:0] b_ff, b_in;

   // a row: leftmost word in cell 0; b row: rightmost word in the last cell
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (cmd.push_left) begin
         a_in = a_left_in;
         if (held == BPos) begin
            b_in = cmd.word;
         end
      end else if (cmd.push_right) begin
         b_in = b_right_in;
         if (held == APos) begin
            a_in = cmd.word;
         end
      end else if (cmd.pop_left) begin
         a_in = a_right_in;
      end else if (cmd.pop_right) begin
         b_in = b_left_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign a_out = a_ff;
   assign b_out = b_ff;

endmodule

[design/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words built from a row of shift cells.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH words in a row of DEPTH cells. Each cell keeps
// two copies of its slot: one row packed against the left end, one packed
// against the right end, so both ends are always read from a fixed cell.
// One word is taken per cycle for as long as the result register is free or
// being emptied in the same cycle; the result appears in the cycle after the
// word is taken. Storage needs no clearing after reset. A push to a full queue
// and a pop from an empty one leave the contents alone and are flagged in the
// status.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int unsigned DEPTH = 256,
   localparam int unsigned CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dq_pkg::MODE_WIDTH-1:0]          req_mode,
   input  logic signed [dq_pkg::WORD_WIDTH-1:0]   req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [dq_pkg::WORD_WIDTH-1:0]   rsp_popped_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic [CountWidth-1:0]                  rsp_element_count,
   output logic [dq_pkg::OP_COUNT_WIDTH-1:0]      rsp_operation_count
);

   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   logic                                  accept;
   logic                                  full;
   logic                                  empty;
   dq_pkg::mode_type                      mode;
   dq_pkg::cmd_type                       cmd;
   dq_pkg::status_type                    status;
   logic [dq_pkg::WORD_WIDTH-1:0]         popped;

   logic [CountWidth-1:0]                 held_ff, held_in;
   logic [dq_pkg::OP_COUNT_WIDTH-1:0]     done_ff, done_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::WORD_WIDTH-1:0]         popped_ff;
   dq_pkg::status_type                    status_ff;
   logic [CountWidth-1:0]                 count_ff;
   logic [dq_pkg::OP_COUNT_WIDTH-1:0]     ops_ff;

   logic [dq_pkg::WORD_WIDTH-1:0]         a_bus [DEPTH];
   logic [dq_pkg::WORD_WIDTH-1:0]         b_bus [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign full = (held_ff == FullCount);
   assign empty = (held_ff == '0);
   assign mode = dq_pkg::mode_type'(req_mode);

   // qualify the operation and work out the word's result
   always_comb begin
      cmd = '0;
      cmd.word = req_value;
      status = dq_pkg::STATUS_DONE;
      popped = dq_pkg::EMPTY_WORD;
      held_in = held_ff;
      done_in = done_ff;
      unique case (mode) inside
         dq_pkg::MODE_PUSH_LEFT, dq_pkg::MODE_PUSH_RIGHT: begin
            if (full) begin
               status = dq_pkg::STATUS_PUSH_FULL;
            end else begin
               cmd.push_left = accept && (mode == dq_pkg::MODE_PUSH_LEFT);
               cmd.push_right = accept && (mode == dq_pkg::MODE_PUSH_RIGHT);
               held_in = held_ff + 1'b1;
               done_in = done_ff + 1'b1;
            end
         end
         dq_pkg::MODE_POP_LEFT, dq_pkg::MODE_POP_RIGHT: begin
            if (empty) begin
               status = dq_pkg::STATUS_POP_EMPTY;
            end else begin
               cmd.pop_left = accept && (mode == dq_pkg::MODE_POP_LEFT);
               cmd.pop_right = accept && (mode == dq_pkg::MODE_POP_RIGHT);
               popped = (mode == dq_pkg::MODE_POP_LEFT) ? a_bus[0] : b_bus[DEPTH-1];
               held_in = held_ff - 1'b1;
               done_in = done_ff + 1'b1;
            end
         end
         default: begin
            status = dq_pkg::STATUS_DONE;
         end
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            held_ff <= held_in;
            done_ff <= done_in;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff <= popped;
         status_ff <= status;
         count_ff <= held_in;
         ops_ff <= done_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [dq_pkg::WORD_WIDTH-1:0] a_left;
      logic [dq_pkg::WORD_WIDTH-1:0] a_right;
      logic [dq_pkg::WORD_WIDTH-1:0] b_left;
      logic [dq_pkg::WORD_WIDTH-1:0] b_right;

      if (i == 0) begin : g_first
         assign a_left = req_value;
         assign b_left = req_value;
      end else begin : g_inner_left
         assign a_left = a_bus[i-1];
         assign b_left = b_bus[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign a_right = req_value;
         assign b_right = req_value;
      end else begin : g_inner_right
         assign a_right = a_bus[i+1];
         assign b_right = b_bus[i+1];
      end

      dq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .held       (held_ff),
         .a_left_in  (a_left),
         .a_right_in (a_right),
         .b_left_in  (b_left),
         .b_right_in (b_right),
         .a_out      (a_bus[i]),
         .b_out      (b_bus[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_status = status_ff;
   assign rsp_element_count = count_ff;
   assign rsp_operation_count = ops_ff;

endmodule
